// File: src/ihdb_pkg.sv
// Shared types and constants for the interpolating history delay buffer.
package ihdb_pkg;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_EMPTY = 3'd1;
    localparam logic [2:0] ST_PAST  = 3'd2;
    localparam logic [2:0] ST_ORDER = 3'd3;
    localparam logic [2:0] ST_FULL  = 3'd4;

    localparam logic [31:0] MAX_DELAY_RESET = 32'd65536;
    localparam logic [0:0]  OP_INSERT = 1'b0;
    localparam logic [0:0]  OP_QUERY  = 1'b1;

    // Memory access selection from the controller.
    localparam logic [2:0] RD_NEWEST = 3'd0;
    localparam logic [2:0] RD_OLDEST = 3'd1;
    localparam logic [2:0] RD_SECOND = 3'd2;
    localparam logic [2:0] RD_MID    = 3'd3;
    localparam logic [2:0] RD_LO     = 3'd4;
    localparam logic [2:0] RD_HI     = 3'd5;

    typedef struct packed {
        logic       load;       // capture input item
        logic       rd_en;      // issue a memory read
        logic [2:0] rd_sel;     // which logical index to read
        logic       cap_newest; // capture read data as newest point
        logic       cap_oldest; // capture read data as oldest point
        logic       cap_second; // capture read data time as second point
        logic       cap_mid;    // apply binary-search step from read data
        logic       cap_lo;     // capture lo point
        logic       cap_hi;     // capture hi point
        logic       wr_newest;  // overwrite value of newest point
        logic       do_append;  // drop as needed and append point
        logic       div_start;  // start the divider
        logic       set_result; // load result register from decision
    } ihdb_cmd_t;

    typedef struct packed {
        logic       is_query;
        logic       empty;
        logic       past;       // query time after newest
        logic       at_oldest;  // query time at or before oldest
        logic       order_bad;  // insert older than newest
        logic       equal_new;  // insert time equals newest
        logic       search_done;
        logic       div_busy;
    } ihdb_sts_t;

endpackage

// File: src/interpolating_history_delay_buffer.sv
// Top level of the interpolating history delay buffer.
// Usage:
//   Input channel (in_valid/in_ready) carries one item: op, time_point, value_in.
//   op 0 inserts a point, op 1 queries the linearly interpolated value at time_point.
//   Output channel (out_valid/out_ready) returns one item per input: value_out, status.
//   The user must write max_delay through APB address 0 only while the block is idle; the block does not enforce it.
// Sequence:
//   One item is in flight at a time. An insert, and a query answered without
//   interpolation, read the newest, oldest and second points and decide before
//   out_valid rises. An interpolated query then runs a binary search of
//   ceil(log2(points - 1)) steps, each one registered memory read, reads the lo and
//   hi points, forms the product and runs the bit-serial 64-by-32 divider.
//   After out_valid is taken the block returns to idle to accept the next item.
//   The single memory read port and the divider set this sequence.
// Reset:
//   rst_n clears the point count, the oldest pointer and the controller, and sets
//   max_delay to 65536; the store contents need no clearing.
// Stall:
//   A result holds on the outputs while out_ready is low; no new item is taken
//   until it has been delivered.
module interpolating_history_delay_buffer #(
    parameter int CAPACITY = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               op,
    input  logic [31:0]        time_point,
    input  logic signed [31:0] value_in,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] value_out,
    output logic [2:0]         status,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [1:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    localparam logic [1:0] ADDR_MAX_DELAY = 2'd0;

    logic [31:0] max_delay_reg;
    ihdb_pkg::ihdb_cmd_t cmd;
    ihdb_pkg::ihdb_sts_t sts;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_MAX_DELAY) ? max_delay_reg : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_delay_reg <= ihdb_pkg::MAX_DELAY_RESET;
        else if (psel && penable && pwrite && paddr == ADDR_MAX_DELAY)
            max_delay_reg <= pwdata;
    end

    ihdb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    ihdb_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .op         (op),
        .time_point (time_point),
        .value_in   (value_in),
        .max_delay  (max_delay_reg),
        .res_value  (value_out),
        .res_status (status)
    );

`ifndef SYNTHESIS
    a_no_accept_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("input taken while a result waits");
    a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(value_out) && $stable(status))
        else $error("result changed while stalled");
    a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready && !out_valid)
        else $error("controller did not start work");
`endif
endmodule

// File: src/ihdb_div.sv
// Restoring divider, one quotient bit per cycle, 64-bit dividend by 32-bit divisor.
module ihdb_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic        busy,
    output logic [63:0] quotient
);
    logic [6:0]  count_reg, count_next;
    logic [63:0] quo_reg, quo_next;
    logic [32:0] rem_reg, rem_next;
    logic [32:0] trial;

    always_comb
    begin
        trial      = {rem_reg[31:0], quo_reg[63]};
        count_next = count_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        if (start)
        begin
            count_next = 7'd64;
            quo_next   = dividend;
            rem_next   = '0;
        end
        else if (count_reg != 7'd0)
        begin
            count_next = count_reg - 7'd1;
            if (trial >= {1'b0, divisor})
            begin
                rem_next = trial - {1'b0, divisor};
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[62:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign busy     = (count_reg != 7'd0);
    assign quotient = quo_reg;
endmodule

// File: src/ihdb_datapath.sv
// Datapath: point store, ring pointers, search registers, interpolation and result.
module ihdb_datapath #(
    parameter int CAPACITY = 1024
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ihdb_pkg::ihdb_cmd_t    cmd,
    output ihdb_pkg::ihdb_sts_t    sts,
    input  logic                   op,
    input  logic [31:0]            time_point,
    input  logic signed [31:0]     value_in,
    input  logic [31:0]            max_delay,
    output logic signed [31:0]     res_value,
    output logic [2:0]             res_status
);
    localparam int AW = $clog2(CAPACITY);
    localparam logic [AW:0] CAP_CNT = (AW+1)'(CAPACITY);
    localparam logic [AW-1:0] LAST_SLOT = AW'(CAPACITY - 1);

    logic [31:0] time_mem [CAPACITY];
    logic [31:0] value_mem [CAPACITY];

    logic [AW-1:0] oldest_reg;
    logic [AW:0]   count_reg;
    logic          op_reg;
    logic [31:0]   t_reg;
    logic [31:0]   v_reg;
    logic [31:0]   rd_t, rd_v;
    logic [31:0]   newest_t_reg, second_t_reg, oldest_t_reg;
    logic [31:0]   newest_v_reg, oldest_v_reg;
    logic [AW:0]   lo_reg, hi_reg;
    logic [31:0]   t1_reg, v1_reg, t2_reg, v2_reg;
    logic [AW:0]   rd_idx;
    logic [AW:0]   mid;
    logic [AW-1:0] rd_addr;
    logic [AW:0]   slot_sum;

    // Ring address of logical index k.
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base, input logic [AW:0] k);
        logic [AW+1:0] s;
        s = {2'b00, base} + {1'b0, k};
        if (s >= (AW+2)'(CAPACITY))
            s = s - (AW+2)'(CAPACITY);
        return s[AW-1:0];
    endfunction

    assign mid = (lo_reg + hi_reg) >> 1;

    always_comb
    begin
        case (cmd.rd_sel)
            ihdb_pkg::RD_NEWEST: rd_idx = count_reg - (AW+1)'(1);
            ihdb_pkg::RD_OLDEST: rd_idx = '0;
            ihdb_pkg::RD_SECOND: rd_idx = (AW+1)'(1);
            ihdb_pkg::RD_MID:    rd_idx = mid;
            ihdb_pkg::RD_LO:     rd_idx = lo_reg;
            ihdb_pkg::RD_HI:     rd_idx = hi_reg;
            default:             rd_idx = '0;
        endcase
    end
    assign rd_addr = slot_of(oldest_reg, rd_idx);

    // Append decision.
    logic          drop_age, drop_full;
    logic [AW-1:0] old_a1;
    logic [AW:0]   cnt_a1;
    logic [AW-1:0] old_a2;
    logic [AW:0]   cnt_a2;
    always_comb
    begin
        drop_age = (count_reg > (AW+1)'(1)) && ((t_reg - second_t_reg) > max_delay);
        old_a1   = oldest_reg;
        cnt_a1   = count_reg;
        if (drop_age)
        begin
            old_a1 = (oldest_reg == LAST_SLOT) ? '0 : oldest_reg + AW'(1);
            cnt_a1 = count_reg - (AW+1)'(1);
        end
        drop_full = (cnt_a1 >= CAP_CNT);
        old_a2    = old_a1;
        cnt_a2    = cnt_a1;
        if (drop_full)
        begin
            old_a2 = (old_a1 == LAST_SLOT) ? '0 : old_a1 + AW'(1);
            cnt_a2 = cnt_a1 - (AW+1)'(1);
        end
        slot_sum = '0;
        slot_sum[AW-1:0] = slot_of(old_a2, cnt_a2);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_t <= time_mem[rd_addr];
            rd_v <= value_mem[rd_addr];
        end
        if (cmd.do_append)
        begin
            time_mem[slot_sum[AW-1:0]]  <= t_reg;
            value_mem[slot_sum[AW-1:0]] <= v_reg;
        end
        else if (cmd.wr_newest)
            value_mem[slot_of(oldest_reg, count_reg - (AW+1)'(1))] <= v_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oldest_reg <= '0;
            count_reg  <= '0;
        end
        else if (cmd.do_append)
        begin
            oldest_reg <= old_a2;
            count_reg  <= cnt_a2 + (AW+1)'(1);
        end
    end

    // Interpolation operands.
    logic signed [32:0] dv;
    logic        dv_neg;
    logic [32:0] mag;
    logic [31:0] dt, span;
    logic [63:0] prod_reg;
    logic        div_busy;
    logic [63:0] quo;

    assign dv     = $signed({v2_reg[31], v2_reg}) - $signed({v1_reg[31], v1_reg});
    assign dv_neg = dv[32];
    assign mag    = dv_neg ? 33'(-dv) : 33'(dv);
    assign dt     = t_reg - t1_reg;
    assign span   = t2_reg - t1_reg;

    ihdb_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (prod_reg),
        .divisor  (span),
        .busy     (div_busy),
        .quotient (quo)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= op;
            t_reg  <= time_point;
            v_reg  <= value_in;
            lo_reg <= '0;
            hi_reg <= '0;
        end
        if (cmd.cap_newest)
        begin
            newest_t_reg <= rd_t;
            newest_v_reg <= rd_v;
            hi_reg       <= count_reg - (AW+1)'(1);
        end
        if (cmd.cap_oldest)
        begin
            oldest_t_reg <= rd_t;
            oldest_v_reg <= rd_v;
        end
        if (cmd.cap_second)
            second_t_reg <= rd_t;
        if (cmd.cap_mid)
        begin
            if (t_reg < rd_t)
                hi_reg <= mid;
            else
                lo_reg <= mid;
        end
        if (cmd.cap_lo)
        begin
            t1_reg <= rd_t;
            v1_reg <= rd_v;
        end
        if (cmd.cap_hi)
        begin
            t2_reg <= rd_t;
            v2_reg <= rd_v;
            prod_reg <= '0;
        end
        else
            prod_reg <= 64'(mag[31:0]) * 64'(dt) + (mag[32] ? {dt, 32'd0} : 64'd0);
    end

    // Result selection.
    logic signed [33:0] interp;
    always_comb
    begin
        interp = dv_neg ? ($signed({{2{v1_reg[31]}}, v1_reg}) - $signed({1'b0, quo[32:0]}))
                        : ($signed({{2{v1_reg[31]}}, v1_reg}) + $signed({1'b0, quo[32:0]}));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.set_result)
        begin
            res_value  <= '0;
            res_status <= ihdb_pkg::ST_OK;
            if (op_reg == ihdb_pkg::OP_INSERT)
            begin
                if (count_reg != '0 && t_reg < newest_t_reg && !cmd.do_append)
                    res_status <= ihdb_pkg::ST_ORDER;
                else if (cmd.do_append && drop_full)
                    res_status <= ihdb_pkg::ST_FULL;
            end
            else if (count_reg == '0)
                res_status <= ihdb_pkg::ST_EMPTY;
            else if (t_reg > newest_t_reg)
            begin
                res_status <= ihdb_pkg::ST_PAST;
                res_value  <= newest_v_reg;
            end
            else if (t_reg <= oldest_t_reg)
                res_value <= oldest_v_reg;
            else if (span == 32'd0)
                res_value <= v1_reg;
            else
                res_value <= interp[31:0];
        end
    end

    assign sts.is_query    = (op_reg == ihdb_pkg::OP_QUERY);
    assign sts.empty       = (count_reg == '0);
    assign sts.past        = (t_reg > newest_t_reg);
    assign sts.at_oldest   = (t_reg <= oldest_t_reg);
    assign sts.order_bad   = (t_reg < newest_t_reg);
    assign sts.equal_new   = (t_reg == newest_t_reg);
    assign sts.search_done = ((lo_reg + (AW+1)'(1)) >= hi_reg);
    assign sts.div_busy    = div_busy;
endmodule

// File: src/ihdb_ctrl.sv
// Controller state machine sequencing inserts, binary search and division.
module ihdb_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output ihdb_pkg::ihdb_cmd_t cmd,
    input  ihdb_pkg::ihdb_sts_t sts
);
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_RDNEW  = 4'd1;
    localparam logic [3:0] S_CAPNEW = 4'd2;
    localparam logic [3:0] S_CAPOLD = 4'd3;
    localparam logic [3:0] S_CAPSEC = 4'd4;
    localparam logic [3:0] S_DECIDE = 4'd5;
    localparam logic [3:0] S_APPEND = 4'd6;
    localparam logic [3:0] S_SRCH   = 4'd7;
    localparam logic [3:0] S_SCAP   = 4'd8;
    localparam logic [3:0] S_CAPLO  = 4'd9;
    localparam logic [3:0] S_CAPHI  = 4'd10;
    localparam logic [3:0] S_MUL    = 4'd11;
    localparam logic [3:0] S_DIV    = 4'd12;
    localparam logic [3:0] S_RES    = 4'd13;
    localparam logic [3:0] S_OUT    = 4'd14;

    logic [3:0] state_reg, state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = (state_reg == S_IDLE);
        out_valid  = (state_reg == S_OUT);
        case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_RDNEW;
                end
            S_RDNEW:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = ihdb_pkg::RD_NEWEST;
                state_next = S_CAPNEW;
            end
            S_CAPNEW:
            begin
                cmd.cap_newest = 1'b1;
                cmd.rd_en      = 1'b1;
                cmd.rd_sel     = ihdb_pkg::RD_OLDEST;
                state_next     = S_CAPOLD;
            end
            S_CAPOLD:
            begin
                cmd.cap_oldest = 1'b1;
                cmd.rd_en      = 1'b1;
                cmd.rd_sel     = ihdb_pkg::RD_SECOND;
                state_next     = S_CAPSEC;
            end
            S_CAPSEC:
            begin
                cmd.cap_second = 1'b1;
                state_next     = S_DECIDE;
            end
            S_DECIDE:
                if (!sts.is_query)
                begin
                    if (!sts.empty && sts.order_bad)
                        state_next = S_RES;
                    else if (!sts.empty && sts.equal_new)
                    begin
                        cmd.wr_newest = 1'b1;
                        state_next    = S_RES;
                    end
                    else
                        state_next = S_APPEND;
                end
                else if (sts.empty || sts.past || sts.at_oldest)
                    state_next = S_RES;
                else
                    state_next = S_SRCH;
            S_APPEND:
            begin
                // The result is built here while the append state is still visible.
                cmd.do_append  = 1'b1;
                cmd.set_result = 1'b1;
                state_next     = S_OUT;
            end
            S_SRCH:
                if (sts.search_done)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = ihdb_pkg::RD_LO;
                    state_next = S_CAPLO;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = ihdb_pkg::RD_MID;
                    state_next = S_SCAP;
                end
            S_SCAP:
            begin
                cmd.cap_mid = 1'b1;
                state_next  = S_SRCH;
            end
            S_CAPLO:
            begin
                cmd.cap_lo = 1'b1;
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = ihdb_pkg::RD_HI;
                state_next = S_CAPHI;
            end
            S_CAPHI:
            begin
                cmd.cap_hi = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
                state_next = S_DIV;
            S_DIV:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_RES;
            end
            S_RES:
                if (!sts.div_busy)
                begin
                    cmd.set_result = 1'b1;
                    state_next     = S_OUT;
                end
            S_OUT:
                if (out_ready)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end
endmodule
